@@ hdl/ray_triangle_hit_test_top_macros.svh @@
// Assertion macros shared by the ray/triangle hit test RTL.
`ifndef RAY_TRIANGLE_HIT_TEST_TOP_MACROS_SVH
`define RAY_TRIANGLE_HIT_TEST_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on clk, ignored while reset is asserted.
`define RTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on clk, also during reset.
`define RTH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RTH_ASSERT(lbl, prop, msg)
`define RTH_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hdl/rthit_pkg.sv @@
// Package: widths, types and helper functions of the ray/triangle hit test.
package rthit_pkg;

  localparam int CW       = 20;          // coordinate width
  localparam int VEC_W    = 3 * CW;      // packed vector width
  localparam int DW       = CW + 1;      // edge / difference width
  localparam int PRW      = 2 * DW;      // cross product term width
  localparam int XW       = PRW + 1;     // cross product width
  localparam int PW       = DW + XW;     // dot product term width
  localparam int SW       = PW + 2;      // dot product sum width
  localparam int QBITS    = 32;          // quotient bits per division
  localparam int OUT_FRAC = 16;          // fraction bits of the results
  localparam int BARY_W   = OUT_FRAC + 1;
  localparam int DIST_W   = 32;
  localparam int THR_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_SIDED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_THRESH   = 1'd1;

  localparam logic [THR_W-1:0]  THRESH_RESET = 32'd2;
  localparam logic [DIST_W-1:0] DIST_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_NEG_MAX = 32'h8000_0000;

  typedef logic signed [DW-1:0]  diff_t;
  typedef logic signed [PRW-1:0] prod_t;
  typedef logic signed [XW-1:0]  xprod_t;
  typedef logic signed [PW-1:0]  dprod_t;
  typedef logic signed [SW-1:0]  wide_t;
  typedef logic [SW-1:0]         mag_t;

  // One division lane: partial remainder, and numerator bits shifting out
  // while quotient bits shift in.
  typedef struct packed {
    mag_t             rem;
    logic [QBITS-1:0] sh;
  } div_lane_t;

  // Sideband that travels with an item through the divider.
  typedef struct packed {
    logic hit;
    logic d_neg;
    logic d_ovf;
  } div_ctl_t;

  // Extract coordinate k of a packed vector, sign extended.
  function automatic diff_t coord(input logic [VEC_W-1:0] v, input int k);
    logic signed [CW-1:0] c;
    c = $signed(v[k*CW +: CW]);
    return diff_t'(c);
  endfunction

  // Load a lane from a numerator magnitude that is later scaled by 2^16.
  function automatic div_lane_t div_init(input mag_t num);
    div_lane_t r;
    r.rem = num >> OUT_FRAC;
    r.sh  = QBITS'(num[OUT_FRAC-1:0]) << (QBITS - OUT_FRAC);
    return r;
  endfunction

  // One restoring division step: develop one quotient bit.
  function automatic div_lane_t div_step(input div_lane_t l, input mag_t d);
    logic [SW:0] t;
    logic [SW:0] dif;
    div_lane_t   r;
    t   = {l.rem, l.sh[QBITS-1]};
    dif = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.rem = dif[SW-1:0];
      r.sh  = {l.sh[QBITS-2:0], 1'b1};
    end else begin
      r.rem = t[SW-1:0];
      r.sh  = {l.sh[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ hdl/rthit_div.sv @@
// Pipelined restoring divider: three numerators over one divisor, one bit a stage.
module rthit_div
  import rthit_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mag_t                      in_det,
  input  logic [2:0][SW-1:0]        in_num,
  input  div_ctl_t                  in_ctl,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0][QBITS-1:0]     out_quo,
  output div_ctl_t                  out_ctl
);

  logic      v_r   [QBITS];
  mag_t      det_r [QBITS];
  div_ctl_t  ctl_r [QBITS];
  div_lane_t lane_r[QBITS][3];
  logic      rdy   [QBITS+1];

  assign rdy[QBITS] = out_ready;
  assign in_ready   = rdy[0];

  genvar g, n;
  generate
    for (g = 0; g < QBITS; g++) begin : g_stage
      assign rdy[g] = !v_r[g] || rdy[g+1];

      if (g == 0) begin : g_first
        // Advance the valid bit when the stage drains or moves on
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[g] <= 1'b0;
          end else if (rdy[g]) begin
            v_r[g] <= in_valid;
          end
        end

        always_ff @(posedge clk) begin
          if (rdy[g]) begin
            det_r[g] <= in_det;
            ctl_r[g] <= in_ctl;
          end
        end
        for (n = 0; n < 3; n++) begin : g_lane
          always_ff @(posedge clk) begin
            if (rdy[g]) lane_r[g][n] <= div_step(div_init(in_num[n]), in_det);
          end
        end
      end else begin : g_rest
        // Advance the valid bit when the stage drains or moves on
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[g] <= 1'b0;
          end else if (rdy[g]) begin
            v_r[g] <= v_r[g-1];
          end
        end

        always_ff @(posedge clk) begin
          if (rdy[g]) begin
            det_r[g] <= det_r[g-1];
            ctl_r[g] <= ctl_r[g-1];
          end
        end
        for (n = 0; n < 3; n++) begin : g_lane
          always_ff @(posedge clk) begin
            if (rdy[g]) lane_r[g][n] <= div_step(lane_r[g-1][n], det_r[g-1]);
          end
        end
      end
    end

    for (n = 0; n < 3; n++) begin : g_out
      assign out_quo[n] = lane_r[QBITS-1][n].sh;
    end
  endgenerate

  assign out_valid = v_r[QBITS-1];
  assign out_ctl   = ctl_r[QBITS-1];

endmodule

@@ hdl/ray_triangle_hit_test_top.sv @@
// Top level of the pipelined ray/triangle hit test.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | origin, direction, vertices a b c
//  out_    | output    | out_valid / out_ready  | hit, hit_distance, bary_u, bary_v
//  cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One request per cycle while the output is not stalled; the path is 8 front stages,
// 32 divider stages (one quotient bit each) and the output register.
// Every stage has its own valid bit and moves when the next one is free,
// so bubbles close up behind a stalled output. Reset is synchronous and
// clears the valid bits and the configuration registers.
`include "ray_triangle_hit_test_top_macros.svh"
module ray_triangle_hit_test_top
  import rthit_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VEC_W-1:0]            in_origin_vec,
  input  logic [VEC_W-1:0]            in_direction_vec,
  input  logic [VEC_W-1:0]            in_vertex_a,
  input  logic [VEC_W-1:0]            in_vertex_b,
  input  logic [VEC_W-1:0]            in_vertex_c,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic signed [DIST_W-1:0]    out_hit_distance,
  output logic [BARY_W-1:0]           out_bary_u,
  output logic [BARY_W-1:0]           out_bary_v,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [THR_W-1:0]            cfg_wdata
);

  // Configuration registers
  logic              double_r;
  logic [THR_W-1:0]  thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_r <= 1'b0;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOUBLE_SIDED: double_r <= cfg_wdata[0];
        REG_PAR_THRESH:   thresh_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Valid bits and ready chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, s7_rdy, s8_rdy;
  logic div_in_ready, div_out_valid, out_rdy, out_valid_r;

  assign out_rdy = !out_valid_r || out_ready;
  assign s8_rdy  = !s8_v_r || div_in_ready;
  assign s7_rdy  = !s7_v_r || s8_rdy;
  assign s6_rdy  = !s6_v_r || s7_rdy;
  assign s5_rdy  = !s5_v_r || s6_rdy;
  assign s4_rdy  = !s4_v_r || s5_rdy;
  assign s3_rdy  = !s3_v_r || s4_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      s5_v_r <= 1'b0; s6_v_r <= 1'b0; s7_v_r <= 1'b0; s8_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (s5_rdy) s5_v_r <= s4_v_r;
      if (s6_rdy) s6_v_r <= s5_v_r;
      if (s7_rdy) s7_v_r <= s6_v_r;
      if (s8_rdy) s8_v_r <= s7_v_r;
    end
  end

  // Stage 1: unpack, form edges and origin offset
  diff_t s1_dir_r[3], s1_e1_r[3], s1_e2_r[3], s1_tv_r[3];
  diff_t dir_nxt[3], e1_nxt[3], e2_nxt[3], tv_nxt[3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir_nxt[k] = coord(in_direction_vec, k);
      e1_nxt[k]  = coord(in_vertex_b, k) - coord(in_vertex_a, k);
      e2_nxt[k]  = coord(in_vertex_c, k) - coord(in_vertex_a, k);
      tv_nxt[k]  = coord(in_origin_vec, k) - coord(in_vertex_a, k);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_dir_r <= dir_nxt;
      s1_e1_r  <= e1_nxt;
      s1_e2_r  <= e2_nxt;
      s1_tv_r  <= tv_nxt;
    end
  end

  // Stage 2: cross product terms of p = dir x e2 and q = tv x e1
  diff_t s2_dir_r[3], s2_e1_r[3], s2_e2_r[3], s2_tv_r[3];
  prod_t s2_pa_r[3], s2_pb_r[3], s2_qa_r[3], s2_qb_r[3];

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_dir_r <= s1_dir_r;
      s2_e1_r  <= s1_e1_r;
      s2_e2_r  <= s1_e2_r;
      s2_tv_r  <= s1_tv_r;
      s2_pa_r[0] <= prod_t'(s1_dir_r[1]) * prod_t'(s1_e2_r[2]);
      s2_pb_r[0] <= prod_t'(s1_dir_r[2]) * prod_t'(s1_e2_r[1]);
      s2_pa_r[1] <= prod_t'(s1_dir_r[2]) * prod_t'(s1_e2_r[0]);
      s2_pb_r[1] <= prod_t'(s1_dir_r[0]) * prod_t'(s1_e2_r[2]);
      s2_pa_r[2] <= prod_t'(s1_dir_r[0]) * prod_t'(s1_e2_r[1]);
      s2_pb_r[2] <= prod_t'(s1_dir_r[1]) * prod_t'(s1_e2_r[0]);
      s2_qa_r[0] <= prod_t'(s1_tv_r[1]) * prod_t'(s1_e1_r[2]);
      s2_qb_r[0] <= prod_t'(s1_tv_r[2]) * prod_t'(s1_e1_r[1]);
      s2_qa_r[1] <= prod_t'(s1_tv_r[2]) * prod_t'(s1_e1_r[0]);
      s2_qb_r[1] <= prod_t'(s1_tv_r[0]) * prod_t'(s1_e1_r[2]);
      s2_qa_r[2] <= prod_t'(s1_tv_r[0]) * prod_t'(s1_e1_r[1]);
      s2_qb_r[2] <= prod_t'(s1_tv_r[1]) * prod_t'(s1_e1_r[0]);
    end
  end

  // Stage 3: finish p and q
  diff_t  s3_dir_r[3], s3_e1_r[3], s3_e2_r[3], s3_tv_r[3];
  xprod_t s3_p_r[3], s3_q_r[3];

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_dir_r <= s2_dir_r;
      s3_e1_r  <= s2_e1_r;
      s3_e2_r  <= s2_e2_r;
      s3_tv_r  <= s2_tv_r;
      for (int k = 0; k < 3; k++) begin
        s3_p_r[k] <= xprod_t'(s2_pa_r[k]) - xprod_t'(s2_pb_r[k]);
        s3_q_r[k] <= xprod_t'(s2_qa_r[k]) - xprod_t'(s2_qb_r[k]);
      end
    end
  end

  // Stage 4: dot product terms of det, u, v and distance
  dprod_t s4_det_r[3], s4_un_r[3], s4_vn_r[3], s4_dn_r[3];

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      for (int k = 0; k < 3; k++) begin
        s4_det_r[k] <= dprod_t'(s3_e1_r[k])  * dprod_t'(s3_p_r[k]);
        s4_un_r[k]  <= dprod_t'(s3_tv_r[k])  * dprod_t'(s3_p_r[k]);
        s4_vn_r[k]  <= dprod_t'(s3_dir_r[k]) * dprod_t'(s3_q_r[k]);
        s4_dn_r[k]  <= dprod_t'(s3_e2_r[k])  * dprod_t'(s3_q_r[k]);
      end
    end
  end

  // Stage 5: sum the dot products
  wide_t s5_det_r, s5_un_r, s5_vn_r, s5_dn_r;

  always_ff @(posedge clk) begin
    if (s5_rdy) begin
      s5_det_r <= wide_t'(s4_det_r[0]) + wide_t'(s4_det_r[1]) + wide_t'(s4_det_r[2]);
      s5_un_r  <= wide_t'(s4_un_r[0])  + wide_t'(s4_un_r[1])  + wide_t'(s4_un_r[2]);
      s5_vn_r  <= wide_t'(s4_vn_r[0])  + wide_t'(s4_vn_r[1])  + wide_t'(s4_vn_r[2]);
      s5_dn_r  <= wide_t'(s4_dn_r[0])  + wide_t'(s4_dn_r[1])  + wide_t'(s4_dn_r[2]);
    end
  end

  // Stage 6: fold a negative determinant in double-sided mode
  wide_t s6_det_r, s6_un_r, s6_vn_r, s6_dn_r;
  logic  flip;

  assign flip = double_r && s5_det_r[SW-1];

  always_ff @(posedge clk) begin
    if (s6_rdy) begin
      s6_det_r <= flip ? -s5_det_r : s5_det_r;
      s6_un_r  <= flip ? -s5_un_r  : s5_un_r;
      s6_vn_r  <= flip ? -s5_vn_r  : s5_vn_r;
      s6_dn_r  <= flip ? -s5_dn_r  : s5_dn_r;
    end
  end

  // Stage 7: determinant and barycentric range tests, distance magnitude and sign
  mag_t  s7_det_r, s7_un_r, s7_vn_r, s7_dn_r;
  logic  s7_hit_r, s7_neg_r;
  wide_t eps_w;
  logic signed [SW:0] uv_sum;
  logic  det_ok, u_ok, v_ok;

  assign eps_w  = wide_t'({1'b0, thresh_r});
  assign uv_sum = (SW+1)'(s6_un_r) + (SW+1)'(s6_vn_r);
  assign det_ok = (s6_det_r != '0) && !(s6_det_r < eps_w);
  assign u_ok   = !s6_un_r[SW-1] && !(s6_un_r > s6_det_r);
  assign v_ok   = !s6_vn_r[SW-1] && !(uv_sum > (SW+1)'(s6_det_r));

  always_ff @(posedge clk) begin
    if (s7_rdy) begin
      s7_det_r <= mag_t'(s6_det_r);
      s7_un_r  <= mag_t'(s6_un_r);
      s7_vn_r  <= mag_t'(s6_vn_r);
      s7_dn_r  <= s6_dn_r[SW-1] ? mag_t'(-s6_dn_r) : mag_t'(s6_dn_r);
      s7_neg_r <= s6_dn_r[SW-1];
      s7_hit_r <= det_ok && u_ok && v_ok;
    end
  end

  // Stage 8: flag a distance quotient that needs more than the kept bits
  mag_t     s8_det_r;
  logic [2:0][SW-1:0] s8_num_r;
  div_ctl_t s8_ctl_r;

  always_ff @(posedge clk) begin
    if (s8_rdy) begin
      s8_det_r       <= s7_det_r;
      s8_num_r[0]    <= s7_un_r;
      s8_num_r[1]    <= s7_vn_r;
      s8_num_r[2]    <= s7_dn_r;
      s8_ctl_r.hit   <= s7_hit_r;
      s8_ctl_r.d_neg <= s7_neg_r;
      s8_ctl_r.d_ovf <= {{OUT_FRAC{1'b0}}, s7_dn_r} >= {s7_det_r, {OUT_FRAC{1'b0}}};
    end
  end

  // Divide u, v and distance numerators by the determinant
  logic [2:0][QBITS-1:0] quo;
  div_ctl_t              dctl;

  rthit_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s8_v_r),
    .in_ready  (div_in_ready),
    .in_det    (s8_det_r),
    .in_num    (s8_num_r),
    .in_ctl    (s8_ctl_r),
    .out_valid (div_out_valid),
    .out_ready (out_rdy),
    .out_quo   (quo),
    .out_ctl   (dctl)
  );

  // Saturate the distance and zero a miss
  logic [DIST_W-1:0] dist_nxt;
  logic [BARY_W-1:0] u_nxt, v_nxt;

  always_comb begin
    dist_nxt = '0;
    u_nxt    = '0;
    v_nxt    = '0;
    if (dctl.hit) begin
      u_nxt = quo[0][BARY_W-1:0];
      v_nxt = quo[1][BARY_W-1:0];
      if (dctl.d_neg) begin
        if (dctl.d_ovf || quo[2] > DIST_NEG_MAX) dist_nxt = DIST_NEG_MAX;
        else                                    dist_nxt = -quo[2];
      end else begin
        if (dctl.d_ovf || quo[2][QBITS-1]) dist_nxt = DIST_POS_MAX;
        else                               dist_nxt = quo[2];
      end
    end
  end

  // Output register
  logic                     hit_r;
  logic signed [DIST_W-1:0] dist_r;
  logic [BARY_W-1:0]        u_r, v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      hit_r  <= dctl.hit;
      dist_r <= $signed(dist_nxt);
      u_r    <= u_nxt;
      v_r    <= v_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_hit_distance = dist_r;
  assign out_bary_u       = u_r;
  assign out_bary_v       = v_r;

  `RTH_ASSERT(a_miss_zero, out_valid_r && !hit_r |-> dist_r == '0 && u_r == '0 && v_r == '0, "miss with nonzero result")
  `RTH_ASSERT(a_bary_sum, out_valid_r && hit_r |-> (BARY_W+1)'(u_r) + (BARY_W+1)'(v_r) <= (BARY_W+1)'(1 << OUT_FRAC), "barycentric sum above one")
  `RTH_ASSERT(a_s8_hold, s8_v_r && !div_in_ready |=> s8_v_r && $stable(s8_det_r), "stage 8 request lost on stall")
  `RTH_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !s1_v_r, "pipeline not empty after reset")

endmodule

@@ tb/tb_ray_triangle_hit_test_top.sv @@
// Self-checking testbench for the pipelined ray/triangle hit test.
module tb_ray_triangle_hit_test_top;
  import rthit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 41;
  localparam int WDOG_MAX = 20000;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [BARY_W-1:0] u;
    logic [BARY_W-1:0] v;
  } hit_result_t;

  typedef logic signed [127:0] s128_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VEC_W-1:0] in_origin_vec = '0, in_direction_vec = '0;
  logic [VEC_W-1:0] in_vertex_a = '0, in_vertex_b = '0, in_vertex_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic signed [DIST_W-1:0] out_hit_distance;
  logic [BARY_W-1:0] out_bary_u, out_bary_v;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DOUBLE_SIDED;
  logic [THR_W-1:0] cfg_wdata = '0;

  // Predictor copy of the configuration registers
  logic              mdl_double_sided = 1'b0;
  logic [THR_W-1:0]  mdl_threshold = THRESH_RESET;

  hit_result_t expected_hits[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  n_sent = 0, n_hits = 0, n_results = 0;

  ray_triangle_hit_test_top u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Unpack one signed coordinate
  function automatic s128_t coord_of(logic [VEC_W-1:0] v, int k);
    logic signed [CW-1:0] c;
    c = v[k*CW +: CW];
    return s128_t'(c);
  endfunction

  // Exact Moller-Trumbore hit test under the current culling settings
  function automatic hit_result_t predict_hit(logic [VEC_W-1:0] org, logic [VEC_W-1:0] dir,
      logic [VEC_W-1:0] a, logic [VEC_W-1:0] b, logic [VEC_W-1:0] c);
    s128_t d[3], e1[3], e2[3], t[3], p[3], q[3];
    s128_t det, un, vn, dn, quo;
    hit_result_t r;
    r = '{1'b0, '0, '0, '0};
    for (int k = 0; k < 3; k++) begin
      d[k]  = coord_of(dir, k);
      e1[k] = coord_of(b, k) - coord_of(a, k);
      e2[k] = coord_of(c, k) - coord_of(a, k);
      t[k]  = coord_of(org, k) - coord_of(a, k);
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = t[1]*e1[2] - t[2]*e1[1];
    q[1] = t[2]*e1[0] - t[0]*e1[2];
    q[2] = t[0]*e1[1] - t[1]*e1[0];
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    un  = t[0]*p[0] + t[1]*p[1] + t[2]*p[2];
    vn  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    dn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det == 0) return r;
    if (mdl_double_sided && det < 0) begin
      det = -det; un = -un; vn = -vn; dn = -dn;
    end
    if (det < s128_t'({1'b0, mdl_threshold})) return r;
    if (un < 0 || un > det || vn < 0 || un + vn > det) return r;
    r.hit = 1'b1;
    r.u = BARY_W'((un <<< 16) / det);
    r.v = BARY_W'((vn <<< 16) / det);
    // Division truncates toward zero, as the block does on magnitudes
    quo = (dn <<< 16) / det;
    if (quo > 64'sh7FFF_FFFF) r.distance = DIST_POS_MAX;
    else if (quo < -64'sh8000_0000) r.distance = DIST_NEG_MAX;
    else r.distance = DIST_W'(quo);
    return r;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(logic [VEC_W-1:0] org, logic [VEC_W-1:0] dir,
      logic [VEC_W-1:0] a, logic [VEC_W-1:0] b, logic [VEC_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_vec <= org;
    in_direction_vec <= dir;
    in_vertex_a <= a;
    in_vertex_b <= b;
    in_vertex_c <= c;
    expected_hits.push_back(predict_hit(org, dir, a, b, c));
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop the input, wait for the pipeline to drain, then write a register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DOUBLE_SIDED) mdl_double_sided = val[0];
    else mdl_threshold = val;
  endtask

  function automatic logic [VEC_W-1:0] pack3(int x, int y, int z);
    return {CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec();
    return VEC_W'({$urandom(), $urandom()});
  endfunction

  // Small coordinate around zero, within plus or minus span, taken as Q12.8
  function automatic int small_coord(int span);
    return $urandom_range(2*span) - span;
  endfunction

  function automatic logic [VEC_W-1:0] small_vec(int span);
    return pack3(small_coord(span), small_coord(span), small_coord(span));
  endfunction

  // Directed corners: hits from both faces, edges, parallel and extremes
  task automatic test_directed();
    logic [VEC_W-1:0] a, b, c, zmax, zmin;
    a = pack3(0, 0, 0);
    b = pack3(256, 0, 0);
    c = pack3(0, 256, 0);
    zmax = {3{1'b0, {(CW-1){1'b1}}}};
    zmin = {3{1'b1, {(CW-1){1'b0}}}};
    send_request(pack3(64, 64, -256), pack3(0, 0, 256), a, b, c);
    send_request(pack3(64, 64, 256), pack3(0, 0, -256), a, b, c);
    send_request(pack3(0, 0, -256), pack3(0, 0, 256), a, b, c);
    send_request(pack3(256, 0, -256), pack3(0, 0, 256), a, b, c);
    send_request(pack3(128, 128, -256), pack3(0, 0, 256), a, b, c);
    send_request(pack3(200, 200, -256), pack3(0, 0, 256), a, b, c);
    send_request(pack3(64, 64, -256), pack3(256, 0, 0), a, b, c);
    send_request(pack3(64, 64, 256), pack3(0, 0, 256), a, b, c);
    send_request(pack3(64, 64, -256), pack3(0, 0, 1), a, b, c);
    send_request(pack3(64, 64, 256), pack3(0, 0, -1), a, b, c);
    send_request(pack3(1, 1, -256), pack3(0, 0, 1), a, pack3(1, 0, 0), pack3(0, 1, 0));
    send_request(zmax, zmin, zmin, zmax, zmin);
    send_request(zmin, zmax, zmax, zmin, zmax);
    send_request({VEC_W{1'b1}}, {VEC_W{1'b1}}, '0, {VEC_W{1'b1}}, zmax);
    send_request(zmax, pack3(0, 0, 1), pack3(-524288, -524288, 0),
                 pack3(524287, -524288, 0), pack3(-524288, 524287, 0));
    send_request(a, a, a, a, a);
  endtask

  // Random requests: mostly rays aimed at small triangles, some raw noise
  task automatic test_random(int count);
    logic [VEC_W-1:0] o, d, a, b, c;
    int sp;
    for (int i = 0; i < count; i++) begin
      sp = ($urandom_range(9) == 0) ? 400000 : (1 << $urandom_range(4, 11));
      if ($urandom_range(9) < 2) begin
        o = rand_vec(); d = rand_vec(); a = rand_vec(); b = rand_vec(); c = rand_vec();
      end else begin
        a = small_vec(sp); b = small_vec(sp); c = small_vec(sp);
        o = small_vec(sp);
        d = ($urandom_range(1)) ? small_vec(sp) : small_vec(sp/8 + 1);
      end
      send_request(o, d, a, b, c);
    end
  endtask

  // Hold the output off long enough for the pipeline to back up
  task automatic test_backpressure();
    hold_off = 200;
    test_random(80);
    hold_off = 0;
  endtask

  task automatic run_phase(int snd, int rcv, int count);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    test_random(count);
  endtask

  // Drive the receiver ready
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    hit_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0b", out_hit);
      end else begin
        exp_r = expected_hits.pop_front();
        if (out_hit) n_hits++;
        if (out_hit !== exp_r.hit || out_hit_distance !== exp_r.distance ||
            out_bary_u !== exp_r.u || out_bary_v !== exp_r.v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b d=%h u=%h v=%h got hit=%0b d=%h u=%h v=%h",
                     exp_r.hit, exp_r.distance, exp_r.u, exp_r.v, out_hit,
                     out_hit_distance, out_bary_u, out_bary_v);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("timeout waiting for handshake");
      $display("tb_ray_triangle_hit_test_top failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_reg(REG_DOUBLE_SIDED, 1);
    test_directed();
    write_reg(REG_PAR_THRESH, 0);
    test_directed();
    run_phase(0, 0, 250);
    write_reg(REG_DOUBLE_SIDED, 0);
    run_phase(58, 0, 250);
    write_reg(REG_PAR_THRESH, 32'hFFFF_FFFF);
    run_phase(0, 58, 150);
    write_reg(REG_PAR_THRESH, 1000);
    run_phase(0, 58, 150);
    write_reg(REG_DOUBLE_SIDED, 1);
    run_phase(15, 15, 250);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    run_phase(0, 0, 150);
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d ray tests, %0d results, %0d hits, over both culling modes",
             n_sent, n_results, n_hits);
    $display("thresholds 0, 2, 1000 and max; idle, stall and hold-off phases run");
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("tb_ray_triangle_hit_test_top passed");
    else
      $display("tb_ray_triangle_hit_test_top failed");
    $finish;
  end

endmodule
